@@ rtl/ces_pkg.sv @@
`default_nettype none

package ces_pkg;

  // Table size and derived widths
  localparam int EVENT_SLOTS = 16;
  localparam int SLOT_W      = $clog2(EVENT_SLOTS);
  localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);
  localparam int TIME_W      = 64;

  // Item kinds
  localparam logic [1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [1:0] KIND_CANCEL   = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;
  localparam logic [1:0] KIND_JUMP     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FIRED     = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // One pending event as held in a cell
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] trigger;
    logic [7:0]        tag;
  } event_t;

  // Queue-wide control from the sequencer
  typedef struct packed {
    logic shift;   // each cell takes its next neighbor's event; the last cell keeps its own
    logic recirc;  // head event goes back to the tail
    logic load;    // append the new event at the tail
  } chain_ctl_t;

  // Per-cell control derived by the chain
  typedef struct packed {
    logic shift;
    logic take_head;
    logic take_new;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ces_cell.sv @@
`default_nettype none

module ces_cell (
  input  logic             clk,
  input  ces_pkg::cell_ctl_t ctl,
  input  ces_pkg::event_t  from_next,
  input  ces_pkg::event_t  head,
  input  ces_pkg::event_t  new_ev,
  output ces_pkg::event_t  ev
);
  import ces_pkg::*;

  // Hold one event; load a new one, or take the neighbor's or the recirculated head
  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      ev <= new_ev;
    end else if (ctl.shift) begin
      ev <= ctl.take_head ? head : from_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ces_chain.sv @@
`default_nettype none

module ces_chain (
  input  logic                     clk,
  input  ces_pkg::chain_ctl_t      ctl,
  input  logic [ces_pkg::CNT_W-1:0] cnt,
  input  ces_pkg::event_t          new_ev,
  output ces_pkg::event_t          head
);
  import ces_pkg::*;

  event_t ev [EVENT_SLOTS];

  assign head = ev[0];

  // Cells 0..cnt-1 hold the pending events, oldest at cell 0
  for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
    cell_ctl_t c_ctl;
    event_t    nb;

    assign c_ctl.shift     = ctl.shift;
    assign c_ctl.take_head = ctl.recirc && (cnt == CNT_W'(i + 1));
    assign c_ctl.take_new  = ctl.load && (cnt == CNT_W'(i));

    if (i == EVENT_SLOTS - 1) begin : g_end
      assign nb = ev[i];
    end else begin : g_mid
      assign nb = ev[i + 1];
    end

    ces_cell u_cell (
      .clk       (clk),
      .ctl       (c_ctl),
      .from_next (nb),
      .head      (ev[0]),
      .new_ev    (new_ev),
      .ev        (ev[i])
    );
  end

endmodule

`default_nettype wire

@@ rtl/cycle_event_scheduler.sv @@
`default_nettype none

// Cycle event scheduler.
// Input channel (in_valid/in_ready) takes one item: schedule, cancel, tick or jump.
// Output channel (out_valid/out_ready) returns result items; last marks the final
// result of an item. Schedule and cancel give exactly one result; tick and jump
// give one result per fired event, or none.
// Pending events sit in a row of cells in insertion order; during a pass the head
// cell is examined each cycle unless firing is paused, and either leaves the row
// or moves to the tail. An item is taken only while the block is idle. With the
// receiver ready, the final result is presented after these steps:
//   schedule, cancel of a free slot: the flush only.
//   cancel of a used slot: one rotation, then the flush.
//   tick: one firing pass, then the flush; with nothing due there is no result.
//   jump: minimum search pass, then firing pass; empty table: no result.
// The next item can be taken while the final result is presented. One event moves
// through the row per cycle, except while firing waits for room at the output.
// A stalled receiver holds the output register; one more result waits in a
// staging register, and firing pauses until there is room.
// Reset zeroes the cycle count and empties the table; no result is pending.
module cycle_event_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] delay,
  input  logic [7:0]  tag,
  input  logic [3:0]  slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  slot_out,
  output logic [7:0]  tag_out,
  output logic [7:0]  lateness,
  output logic        last
);
  import ces_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MIN    = 3'd1;
  localparam logic [2:0] S_FIRE   = 3'd2;
  localparam logic [2:0] S_CANCEL = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  // Control registers
  logic [2:0]             state, state_next;
  logic [TIME_W-1:0]      now_cycle, now_cycle_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [EVENT_SLOTS-1:0] slot_valid, slot_valid_next;
  logic                   hold_valid, hold_valid_next;
  logic                   out_valid_next;

  // Payload registers
  logic [CNT_W-1:0]       rem, rem_next;
  logic [TIME_W-1:0]      min_trig, min_trig_next;
  logic [SLOT_W-1:0]      cancel_idx, cancel_idx_next;
  logic [2:0]             hold_status, hold_status_next;
  logic [3:0]             hold_slot, hold_slot_next;
  logic [7:0]             hold_tag, hold_tag_next;
  logic [7:0]             hold_late, hold_late_next;
  logic [2:0]             status_next;
  logic [3:0]             slot_out_next;
  logic [7:0]             tag_out_next;
  logic [7:0]             lateness_next;
  logic                   last_next;

  chain_ctl_t             ctl;
  event_t                 new_ev;
  event_t                 head;

  logic                   out_free;
  logic                   full;
  logic [SLOT_W-1:0]      free_idx;
  logic                   cancel_hit;
  logic                   head_due;
  logic [TIME_W-1:0]      late_diff;
  logic [7:0]             late_sat;

  ces_chain u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .cnt    (cnt),
    .new_ev (new_ev),
    .head   (head)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign full     = &slot_valid;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = SLOT_W'(i);
    end
  end

  assign cancel_hit = (32'(slot) < EVENT_SLOTS) && slot_valid[SLOT_W'(slot)];

  // Head event check
  assign head_due  = (head.trigger <= now_cycle);
  assign late_diff = now_cycle - head.trigger;
  assign late_sat  = (|late_diff[TIME_W-1:8]) ? 8'hff : late_diff[7:0];

  assign new_ev.slot    = free_idx;
  assign new_ev.trigger = now_cycle + TIME_W'(delay);
  assign new_ev.tag     = tag;

  // Sequencer
  always_comb begin
    state_next       = state;
    now_cycle_next   = now_cycle;
    cnt_next         = cnt;
    slot_valid_next  = slot_valid;
    hold_valid_next  = hold_valid;
    out_valid_next   = out_valid && !out_ready;
    rem_next         = rem;
    min_trig_next    = min_trig;
    cancel_idx_next  = cancel_idx;
    hold_status_next = hold_status;
    hold_slot_next   = hold_slot;
    hold_tag_next    = hold_tag;
    hold_late_next   = hold_late;
    status_next      = status;
    slot_out_next    = slot_out;
    tag_out_next     = tag_out;
    lateness_next    = lateness;
    last_next        = last;
    ctl              = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_SCHEDULE: begin
              hold_valid_next = 1'b1;
              hold_tag_next   = '0;
              hold_late_next  = '0;
              state_next      = S_FLUSH;
              if (full) begin
                hold_status_next = ST_FULL;
                hold_slot_next   = '0;
              end else begin
                hold_status_next          = ST_SCHEDULED;
                hold_slot_next            = 4'(free_idx);
                ctl.load                  = 1'b1;
                cnt_next                  = cnt + 1'b1;
                slot_valid_next[free_idx] = 1'b1;
              end
            end
            KIND_CANCEL: begin
              hold_valid_next = 1'b1;
              hold_slot_next  = slot;
              hold_tag_next   = '0;
              hold_late_next  = '0;
              if (cancel_hit) begin
                hold_status_next                   = ST_CANCELLED;
                cancel_idx_next                    = SLOT_W'(slot);
                slot_valid_next[SLOT_W'(slot)]     = 1'b0;
                rem_next                           = cnt;
                state_next                         = S_CANCEL;
              end else begin
                hold_status_next = ST_EMPTY;
                state_next       = S_FLUSH;
              end
            end
            KIND_TICK: begin
              now_cycle_next = now_cycle + 1'b1;
              rem_next       = cnt;
              state_next     = (cnt == '0) ? S_IDLE : S_FIRE;
            end
            KIND_JUMP: begin
              rem_next   = cnt;
              state_next = (cnt == '0) ? S_IDLE : S_MIN;
            end
          endcase
        end
      end

      // Rotate once through the row, tracking the smallest trigger
      S_MIN: begin
        if (rem != '0) begin
          ctl.shift  = 1'b1;
          ctl.recirc = 1'b1;
          rem_next   = rem - 1'b1;
          if (rem == cnt || head.trigger < min_trig) min_trig_next = head.trigger;
        end else begin
          now_cycle_next = min_trig;
          rem_next       = cnt;
          state_next     = S_FIRE;
        end
      end

      // Rotate once, dropping due events in insertion order
      S_FIRE: begin
        if (rem != '0) begin
          if (head_due) begin
            if (!hold_valid || out_free) begin
              ctl.shift                  = 1'b1;
              cnt_next                   = cnt - 1'b1;
              rem_next                   = rem - 1'b1;
              slot_valid_next[head.slot] = 1'b0;
              if (hold_valid) begin
                out_valid_next = 1'b1;
                status_next    = hold_status;
                slot_out_next  = hold_slot;
                tag_out_next   = hold_tag;
                lateness_next  = hold_late;
                last_next      = 1'b0;
              end
              hold_valid_next  = 1'b1;
              hold_status_next = ST_FIRED;
              hold_slot_next   = 4'(head.slot);
              hold_tag_next    = head.tag;
              hold_late_next   = late_sat;
            end
          end else begin
            ctl.shift  = 1'b1;
            ctl.recirc = 1'b1;
            rem_next   = rem - 1'b1;
          end
        end else begin
          state_next = hold_valid ? S_FLUSH : S_IDLE;
        end
      end

      // Rotate once, dropping the cancelled slot
      S_CANCEL: begin
        if (rem != '0) begin
          ctl.shift  = 1'b1;
          ctl.recirc = (head.slot != cancel_idx);
          rem_next   = rem - 1'b1;
          if (head.slot == cancel_idx) cnt_next = cnt - 1'b1;
        end else begin
          state_next = S_FLUSH;
        end
      end

      // Final result of the item
      S_FLUSH: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          status_next     = hold_status;
          slot_out_next   = hold_slot;
          tag_out_next    = hold_tag;
          lateness_next   = hold_late;
          last_next       = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_cycle  <= '0;
      cnt        <= '0;
      slot_valid <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      now_cycle  <= now_cycle_next;
      cnt        <= cnt_next;
      slot_valid <= slot_valid_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rem         <= rem_next;
    min_trig    <= min_trig_next;
    cancel_idx  <= cancel_idx_next;
    hold_status <= hold_status_next;
    hold_slot   <= hold_slot_next;
    hold_tag    <= hold_tag_next;
    hold_late   <= hold_late_next;
    status      <= status_next;
    slot_out    <= slot_out_next;
    tag_out     <= tag_out_next;
    lateness    <= lateness_next;
    last        <= last_next;
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(EVENT_SLOTS))
    else $error("event count above table size");

  a_cnt_matches: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(slot_valid) == 32'(cnt)))
    else $error("valid slots disagree with queued events");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("staged result left behind at idle");

endmodule

`default_nettype wire
